>>> rtl/spq_pkg.sv
// Package for the sorted-insertion priority queue.
// Holds the item codes, result status codes and the command struct broadcast to the slots.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    // func field codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    // broadcast to every slot for one transfer
    typedef struct packed {
        logic                     ins_en;  // insert that will be stored
        logic                     rem_en;  // remove that will pop the front
        logic signed [DATA_W-1:0] value;
    } spq_cmd_t;

endpackage

`default_nettype wire

>>> rtl/sorted_insert_priority_queue_top.sv
// Top level of the sorted-insertion priority queue.
// Depends on spq_pkg and spq_slot.
`default_nettype none

// Priority queue of signed 32-bit values kept in ascending order in CAPACITY
// slot registers. A transfer (start high, busy low) is taken into an input
// register; in the next cycle every slot compares its entry with the value in
// parallel and shifts or loads in one pass, and the result register drives
// data/status/occupancy with done high for exactly one cycle. busy is never
// raised: one item can be taken every cycle, and each item sees the queue as
// left by the item before it. The receiver cannot stall, so results must be
// captured on the cycle done is high.
// Insert places the value ahead of the first entry >= it; when full it is
// dropped with status 1. Remove pops the smallest entry into data; on an
// empty queue status is 2. data is zero unless a remove succeeds. occupancy
// is the fill count after the item, kept to its low five bits.
module sorted_insert_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     func,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          done,
    output logic signed [DATA_W-1:0]      data,
    output logic [1:0]                    status,
    output logic [OCC_W-1:0]              occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    // input register
    logic                     in_valid_reg;
    logic                     func_reg;
    logic signed [DATA_W-1:0] value_reg;

    // queue state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic                     done_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    spq_status_t              status_reg;
    spq_status_t              status_next;
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;
    logic [CNT_W+OCC_W-1:0]   count_wide;

    spq_cmd_t cmd;
    logic                     is_full;
    logic                     is_empty;

    logic                     take     [CAPACITY];
    logic signed [DATA_W-1:0] entry_q  [CAPACITY];

    assign busy = 1'b0;

    // capture the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg  <= func;
            value_reg <= value;
        end
    end

    // decode against the current fill
    assign is_full  = (count_reg >= CAP);
    assign is_empty = (count_reg == '0);

    assign cmd.ins_en = in_valid_reg && (func_reg == FUNC_INSERT) && !is_full;
    assign cmd.rem_en = in_valid_reg && (func_reg == FUNC_REMOVE) && !is_empty;
    assign cmd.value  = value_reg;

    // slot array: each slot sees only its neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_slot
        logic                     prev_take_w;
        logic signed [DATA_W-1:0] prev_entry_w;
        logic signed [DATA_W-1:0] next_entry_w;

        if (i == 0)
        begin : g_first
            assign prev_take_w  = 1'b0;
            assign prev_entry_w = entry_q[i];
        end
        else
        begin : g_mid
            assign prev_take_w  = take[i-1];
            assign prev_entry_w = entry_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_entry_w = entry_q[i];
        end
        else
        begin : g_inner
            assign next_entry_w = entry_q[i+1];
        end

        spq_slot #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_slot (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .prev_take  (prev_take_w),
            .prev_entry (prev_entry_w),
            .next_entry (next_entry_w),
            .take       (take[i]),
            .entry      (entry_q[i])
        );
    end

    // fill count and result
    always_comb
    begin
        count_next  = count_reg;
        data_next   = '0;
        status_next = ST_OK;
        if (in_valid_reg)
        begin
            if (func_reg == FUNC_INSERT)
            begin
                if (is_full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            else
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else
                begin
                    data_next  = entry_q[0];
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    // occupancy is the low five bits of the new count
    assign count_wide = {{OCC_W{1'b0}}, count_next};
    assign occ_next   = count_wide[OCC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
            occ_reg    <= occ_next;
        end
    end

    assign done      = done_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    // fill never exceeds the slot count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("fill count above capacity");

    // a result follows exactly one captured transfer
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done_reg)
        else $error("result strobe missing");

    // a full drop leaves the queue full
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FULL) |-> count_reg == CAP)
        else $error("full drop with room left");

    // a remove on empty leaves the queue empty
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_EMPTY) |-> (count_reg == '0 && data_reg == '0))
        else $error("empty remove with entries or nonzero data");

endmodule

`default_nettype wire

>>> rtl/spq_slot.sv
// One storage slot of the sorted queue: entry register plus its compare/shift mux.
// Depends on spq_pkg.
`default_nettype none

module spq_slot
    import spq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  wire logic                     clk,
    input  wire spq_cmd_t                 cmd,
    input  wire logic [CNT_W-1:0]         count,
    input  wire logic                     prev_take,
    input  wire logic signed [DATA_W-1:0] prev_entry,
    input  wire logic signed [DATA_W-1:0] next_entry,
    output logic                          take,
    output logic signed [DATA_W-1:0]      entry
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    // at or past the insert point: first stored entry >= value, or beyond the fill
    assign take = (IDX >= count) || (entry_reg >= cmd.value);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_en)
        begin
            if (prev_take)
                entry_next = prev_entry;
            else if (take)
                entry_next = cmd.value;
        end
        else if (cmd.rem_en)
        begin
            entry_next = next_entry;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking bench for sorted_insert_priority_queue_top: drives insert and remove
// transfers, predicts each result with a local sorted-queue model and checks every done.
// Depends on spq_pkg and the queue RTL only.
`default_nettype none

module testbench;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY       = 16;
    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int RESULT_LATENCY = 2;     // done follows the transfer through the input and result registers
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer and no result
    localparam int PRINT_CAP      = 60;    // mismatches beyond this are only counted

    // One expected result, already in port widths.
    typedef struct {
        logic signed [DATA_W-1:0] data;
        spq_status_t              status;
        logic [OCC_W-1:0]         occupancy;
    } queue_result_t;

    // Sorted-queue checker: keeps its own copy of the stored entries, works out
    // the result of every accepted transfer and compares results in order.
    class sorted_queue_checker;
        logic signed [DATA_W-1:0] stored[$];        // ascending, front = smallest
        queue_result_t            expected_results[$];
        int                       errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP)
                $display("mismatch at %0t ns: %s", $time, msg);
            errors++;
        endtask

        // Apply one accepted transfer to the model and queue up its result.
        function void note_transfer(logic f, logic signed [DATA_W-1:0] v);
            queue_result_t res;
            int            pos;
            res.data   = '0;
            res.status = ST_OK;
            if (f == FUNC_INSERT) begin
                if (stored.size() >= CAPACITY)
                    res.status = ST_FULL;
                else begin
                    // new value lands ahead of the first entry >= it
                    pos = 0;
                    while (pos < stored.size() && stored[pos] < v)
                        pos++;
                    stored.insert(pos, v);
                end
            end else begin
                if (stored.size() == 0)
                    res.status = ST_EMPTY;
                else
                    res.data = stored.pop_front();
            end
            res.occupancy = OCC_W'(stored.size());
            expected_results.push_back(res);
        endfunction

        task check_result(logic signed [DATA_W-1:0] d, logic [1:0] s, logic [OCC_W-1:0] o);
            queue_result_t exp_res;
            if (expected_results.size() == 0) begin
                report("result with no transfer outstanding");
                return;
            end
            exp_res = expected_results.pop_front();
            if (d !== exp_res.data)
                report($sformatf("data %0d, wanted %0d", d, exp_res.data));
            if (s !== exp_res.status)
                report($sformatf("status %0d, wanted %s", s, exp_res.status.name()));
            if (o !== exp_res.occupancy)
                report($sformatf("occupancy %0d, wanted %0d", o, exp_res.occupancy));
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     func = FUNC_INSERT;
    logic signed [DATA_W-1:0] value = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;

    sorted_queue_checker checker_h = new();
    int                  idle_pct = 0;     // chance in 100 that the sender idles a cycle
    int                  quiet_cycles = 0;

    sorted_insert_priority_queue_top #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .value     (value),
        .done      (done),
        .data      (data),
        .status    (status),
        .occupancy (occupancy)
    );

    always #HALF_PERIOD clk = ~clk;

    // Monitor: everything is sampled at the edge, before any register updates.
    // The transfer is noted first so a result in the same cycle would still find it.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            checker_h.note_transfer(func, value);
        if (rst_n && done)
            checker_h.check_result(data, status, occupancy);
    end

    // Watchdog: a run that stops moving is a failure.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one item and hold it until the transfer happens. Idle cycles are
    // inserted ahead of it at the current rate; start stays high between
    // back-to-back items so no edge is lost.
    task automatic send_item(input logic f, input logic signed [DATA_W-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        func  <= f;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (checker_h.pending() != 0)
            @(posedge clk);
    endtask

    // Value mix: half full-range random, plus a narrow band and a +/-1000 band for duplicates
    // and the signed extremes so ties and the sign boundary get exercised.
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6:          v = $signed($urandom_range(8)) - 4;
            7:             v = ($urandom_range(1) == 1) ? 32'sh7fffffff : 32'sh80000000;
            default:       v = $signed($urandom_range(2000)) - 1000;
        endcase
        return v;
    endfunction

    // Random phase: the insert share changes every few dozen items so the
    // queue keeps swinging between empty and full and both flags get hit.
    task automatic random_phase(input int n_items);
        int ins_pct;
        int k;
        ins_pct = 50;
        for (k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(4))
                    0:       ins_pct = 5;
                    1:       ins_pct = 25;
                    2:       ins_pct = 50;
                    3:       ins_pct = 75;
                    default: ins_pct = 95;
                endcase
            end
            if ($urandom_range(99) < ins_pct)
                send_item(FUNC_INSERT, pick_value());
            else
                send_item(FUNC_REMOVE, $urandom);   // value ignored on remove
        end
    endtask

    logic signed [DATA_W-1:0] fill_values [CAPACITY] = '{
        32'sh7fffffff, 32'sh80000000, 32'sh00000000, -32'sd1,
        32'sd1,        32'sd5,        32'sd5,        -32'sd5,
        32'sh40000000, 32'shbfffffff, 32'sd5,        32'sh7ffffffe,
        32'sh80000001, 32'sh55555555, 32'shaaaaaaaa, 32'sd0
    };

    initial
    begin
        int i;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back: remove on empty, fill with extremes
        // and duplicates, insert into a full queue, pop three entries, insert, pop again.
        idle_pct = 0;
        send_item(FUNC_REMOVE, 32'sh12345678);
        for (i = 0; i < CAPACITY; i++)
            send_item(FUNC_INSERT, fill_values[i]);
        send_item(FUNC_INSERT, 32'sh80000000);
        send_item(FUNC_REMOVE, '0);
        send_item(FUNC_REMOVE, '0);
        send_item(FUNC_REMOVE, '0);
        send_item(FUNC_INSERT, 32'sh80000000);
        send_item(FUNC_REMOVE, '0);

        // Sender stays away until the pipeline has emptied completely.
        wait_drained();

        // Random phases at different sender idle rates, with stretches of none.
        idle_pct = 0;
        random_phase(500);
        idle_pct = 82;
        random_phase(450);
        wait_drained();
        idle_pct = 13;
        random_phase(500);
        idle_pct = 0;
        random_phase(480);

        // Let the last results come home, then keep watching for a stray done.
        wait_drained();
        repeat (RESULT_LATENCY + 4) @(posedge clk);
        if (checker_h.pending() != 0)
            checker_h.report($sformatf("%0d results never arrived", checker_h.pending()));

        if (checker_h.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
